@@ hdl/pfb_pkg.sv @@
`default_nettype none
package pfb_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEFF_W   = 16;
  localparam int IDX_W     = 12;
  localparam int MAX_CH    = 4;
  localparam int NUM_BANKS = 4;
  localparam int BANK_W    = 2;
  localparam int POS_W_MAX = 16;
  localparam int PROD_W    = SAMPLE_W + COEFF_W;

  localparam int FRAME_LEN_DEF       = 1024;
  localparam int TAP_COUNT_DEF       = 4;
  localparam int CHANNEL_COUNT_DEF   = 4;
  localparam int COEFF_FRAC_BITS_DEF = 15;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic MODE_COEFF  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // one classified item between front and back
  typedef struct packed {
    logic                               mode;
    logic                               wr_ok;
    logic [BANK_W-1:0]                  tap;
    logic [COEFF_W-1:0]                 coeff;
    logic [POS_W_MAX-1:0]               pos;
    logic [BANK_W-1:0]                  bank;
    logic [BANK_W-1:0]                  fdone;
    logic                               last;
    logic [MAX_CH-1:0][SAMPLE_W-1:0]    smp_i;
    logic [MAX_CH-1:0][SAMPLE_W-1:0]    smp_q;
  } pfb_item_t;

endpackage
`default_nettype wire

@@ hdl/pfb_ram.sv @@
`default_nettype none
module pfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ hdl/pfb_front.sv @@
`default_nettype none
module pfb_front import pfb_pkg::*; #(
  parameter int FRAME_LEN = FRAME_LEN_DEF,
  parameter int TAP_COUNT = TAP_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_mode,
  input  wire logic [IDX_W-1:0]                in_coeff_index,
  input  wire logic [COEFF_W-1:0]              in_coeff_value,
  input  wire logic [MAX_CH-1:0][SAMPLE_W-1:0] in_smp_i,
  input  wire logic [MAX_CH-1:0][SAMPLE_W-1:0] in_smp_q,
  input  wire logic                            q_full,
  output logic                                 push,
  output pfb_item_t                            item
);

  localparam int PW = $clog2(FRAME_LEN);

  logic [PW-1:0]     pos_r;
  logic [BANK_W-1:0] bank_r;
  logic [BANK_W-1:0] fd_r;
  logic              fv_r;
  pfb_item_t         item_r;
  pfb_item_t         item_nxt;
  logic              accept;
  logic              last;
  logic [BANK_W-1:0] tap_sel;
  logic [31:0]       base;
  logic [31:0]       idx_ext;

  assign in_stall = fv_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = fv_r && !q_full;
  assign item     = item_r;
  assign last     = (pos_r == PW'(FRAME_LEN - 1));
  assign idx_ext  = 32'(in_coeff_index);

  // split coefficient address into tap and position
  always_comb begin
    tap_sel = '0;
    base    = '0;
    for (int t = 1; t < TAP_COUNT; t++) begin
      if (idx_ext >= 32'(t * FRAME_LEN)) begin
        tap_sel = BANK_W'(t);
        base    = 32'(t * FRAME_LEN);
      end
    end
  end

  always_comb begin
    item_nxt       = '0;
    item_nxt.mode  = in_mode;
    item_nxt.smp_i = in_smp_i;
    item_nxt.smp_q = in_smp_q;
    item_nxt.bank  = bank_r;
    item_nxt.fdone = fd_r;
    if (in_mode == MODE_COEFF) begin
      item_nxt.wr_ok = idx_ext < 32'(TAP_COUNT * FRAME_LEN);
      item_nxt.tap   = tap_sel;
      item_nxt.coeff = in_coeff_value;
      item_nxt.pos   = POS_W_MAX'(idx_ext - base);
    end else begin
      item_nxt.pos  = POS_W_MAX'(pos_r);
      item_nxt.last = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r   <= 1'b0;
      pos_r  <= '0;
      bank_r <= '0;
      fd_r   <= '0;
    end else begin
      if (accept) begin
        fv_r <= 1'b1;
      end else if (push) begin
        fv_r <= 1'b0;
      end
      if (accept && in_mode == MODE_SAMPLE) begin
        if (last) begin
          pos_r  <= '0;
          bank_r <= bank_r + 1'b1;
          if (fd_r != '1) begin
            fd_r <= fd_r + 1'b1;
          end
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_mode == MODE_SAMPLE && last |=> pos_r == '0)
    else $error("frame position did not wrap");

endmodule
`default_nettype wire

@@ hdl/pfb_queue.sv @@
`default_nettype none
module pfb_queue import pfb_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire pfb_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           q_valid,
  output pfb_item_t      pop_item
);

  localparam int AW = $clog2(DEPTH);

  pfb_item_t     mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [AW:0]   cnt_r;

  assign full     = (cnt_r == (AW + 1)'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

@@ hdl/pfb_back.sv @@
`default_nettype none
module pfb_back import pfb_pkg::*; #(
  parameter int FRAME_LEN       = FRAME_LEN_DEF,
  parameter int TAP_COUNT       = TAP_COUNT_DEF,
  parameter int CHANNEL_COUNT   = CHANNEL_COUNT_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      q_valid,
  input  wire pfb_item_t                 q_item,
  output logic                           pop,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [MAX_CH-1:0][SAMPLE_W-1:0] out_i,
  output logic [MAX_CH-1:0][SAMPLE_W-1:0] out_q,
  output logic                           out_last
);

  localparam int PW    = $clog2(FRAME_LEN);
  localparam int HW    = CHANNEL_COUNT * 2 * SAMPLE_W;
  localparam int PADW  = MAX_CH * 2 * SAMPLE_W;
  localparam int ACC_W = PROD_W + 2;

  logic                 adv;
  logic [PW-1:0]        addr;
  logic [HW-1:0]        hist_wdata;
  logic [HW-1:0]        hist_rd  [NUM_BANKS];
  logic [PADW-1:0]      hist_pad [NUM_BANKS];
  logic [COEFF_W-1:0]   coeff_rd [NUM_BANKS];

  logic                            s1_v_r;
  logic                            s1_last_r;
  logic [BANK_W-1:0]               s1_bank_r;
  logic [BANK_W-1:0]               s1_fd_r;
  logic [MAX_CH-1:0][SAMPLE_W-1:0] s1_i_r;
  logic [MAX_CH-1:0][SAMPLE_W-1:0] s1_q_r;

  logic                     s2_v_r;
  logic                     s2_last_r;
  logic signed [PROD_W-1:0] p_i_r   [MAX_CH][NUM_BANKS];
  logic signed [PROD_W-1:0] p_q_r   [MAX_CH][NUM_BANKS];
  logic signed [PROD_W-1:0] p_i_nxt [MAX_CH][NUM_BANKS];
  logic signed [PROD_W-1:0] p_q_nxt [MAX_CH][NUM_BANKS];

  logic                            out_valid_r;
  logic                            out_last_r;
  logic [MAX_CH-1:0][SAMPLE_W-1:0] out_i_r;
  logic [MAX_CH-1:0][SAMPLE_W-1:0] out_q_r;
  logic [MAX_CH-1:0][SAMPLE_W-1:0] out_i_nxt;
  logic [MAX_CH-1:0][SAMPLE_W-1:0] out_q_nxt;

  assign adv  = !out_valid_r || !out_stall;
  assign pop  = adv && q_valid;
  assign addr = q_item.pos[PW-1:0];

  always_comb begin
    hist_wdata = '0;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      hist_wdata[c*2*SAMPLE_W +: 2*SAMPLE_W] = {q_item.smp_q[c], q_item.smp_i[c]};
    end
  end

  // one coefficient ram per tap, one history ram per bank
  for (genvar t = 0; t < NUM_BANKS; t++) begin : g_tap
    if (t < TAP_COUNT) begin : g_coeff
      pfb_ram #(.WIDTH(COEFF_W), .DEPTH(FRAME_LEN)) u_coeff (
        .clk   (clk),
        .we    (pop && q_item.mode == MODE_COEFF && q_item.wr_ok &&
                q_item.tap == BANK_W'(t)),
        .waddr (addr),
        .wdata (q_item.coeff),
        .re    (adv),
        .raddr (addr),
        .rdata (coeff_rd[t])
      );
    end else begin : g_nocoeff
      assign coeff_rd[t] = '0;
    end
    pfb_ram #(.WIDTH(HW), .DEPTH(FRAME_LEN)) u_hist (
      .clk   (clk),
      .we    (pop && q_item.mode == MODE_SAMPLE && q_item.bank == BANK_W'(t)),
      .waddr (addr),
      .wdata (hist_wdata),
      .re    (adv),
      .raddr (addr),
      .rdata (hist_rd[t])
    );
    assign hist_pad[t] = PADW'(hist_rd[t]);
  end

  // products: tap 0 is the fresh sample, older taps only once their frame exists
  always_comb begin
    logic [SAMPLE_W-1:0] si;
    logic [SAMPLE_W-1:0] sq;
    logic [BANK_W-1:0]   b;
    for (int c = 0; c < MAX_CH; c++) begin
      for (int t = 0; t < NUM_BANKS; t++) begin
        b  = s1_bank_r - BANK_W'(t);
        si = '0;
        sq = '0;
        if (t == 0) begin
          si = s1_i_r[c];
          sq = s1_q_r[c];
        end else if (s1_fd_r >= BANK_W'(t)) begin
          si = hist_pad[b][c*2*SAMPLE_W +: SAMPLE_W];
          sq = hist_pad[b][c*2*SAMPLE_W + SAMPLE_W +: SAMPLE_W];
        end
        if (c < CHANNEL_COUNT && t < TAP_COUNT) begin
          p_i_nxt[c][t] = $signed(si) * $signed(coeff_rd[t]);
          p_q_nxt[c][t] = $signed(sq) * $signed(coeff_rd[t]);
        end else begin
          p_i_nxt[c][t] = '0;
          p_q_nxt[c][t] = '0;
        end
      end
    end
  end

  // tap sum, floor shift, wrap to sample width
  always_comb begin
    logic signed [ACC_W-1:0] ai;
    logic signed [ACC_W-1:0] aq;
    for (int c = 0; c < MAX_CH; c++) begin
      ai = '0;
      aq = '0;
      for (int t = 0; t < NUM_BANKS; t++) begin
        ai = ai + ACC_W'(p_i_r[c][t]);
        aq = aq + ACC_W'(p_q_r[c][t]);
      end
      ai = ai >>> COEFF_FRAC_BITS;
      aq = aq >>> COEFF_FRAC_BITS;
      out_i_nxt[c] = ai[SAMPLE_W-1:0];
      out_q_nxt[c] = aq[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= pop && q_item.mode == MODE_SAMPLE;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r  <= q_item.last;
      s1_bank_r  <= q_item.bank;
      s1_fd_r    <= q_item.fdone;
      s1_i_r     <= q_item.smp_i;
      s1_q_r     <= q_item.smp_q;
      s2_last_r  <= s1_last_r;
      p_i_r      <= p_i_nxt;
      p_q_r      <= p_q_nxt;
      out_last_r <= s2_last_r;
      out_i_r    <= out_i_nxt;
      out_q_r    <= out_q_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_last  = out_last_r;
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_i_r) && $stable(out_q_r))
    else $error("result changed while stalled");

endmodule
`default_nettype wire

@@ hdl/polyphase_filter_bank_frontend_top.sv @@
`default_nettype none
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   mode, coefficient write, four I/Q samples
// out_      output     out_valid / out_stall four filtered I/Q pairs, frame_last
//
// one item per clock sustained while out_stall is low; after a sample item is accepted,
// its result passes the front register, queue write, ram read, multiply and tap sum
// the rate is set by one read of each tap and bank ram per cycle
// coefficient items produce no result and only write the coefficient ram
// history reads from frames not yet filled are masked by a frame count, no clear pass
// reset is synchronous, active low; out_stall freezes the back, the queue absorbs the front
module polyphase_filter_bank_frontend_top import pfb_pkg::*; #(
  parameter int FRAME_LEN       = FRAME_LEN_DEF,
  parameter int TAP_COUNT       = TAP_COUNT_DEF,
  parameter int CHANNEL_COUNT   = CHANNEL_COUNT_DEF,
  parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_mode,
  input  wire logic [IDX_W-1:0]    in_coeff_index,
  input  wire logic signed [15:0]  in_coeff_value,
  input  wire logic signed [15:0]  in_ch0_in_i,
  input  wire logic signed [15:0]  in_ch0_in_q,
  input  wire logic signed [15:0]  in_ch1_in_i,
  input  wire logic signed [15:0]  in_ch1_in_q,
  input  wire logic signed [15:0]  in_ch2_in_i,
  input  wire logic signed [15:0]  in_ch2_in_q,
  input  wire logic signed [15:0]  in_ch3_in_i,
  input  wire logic signed [15:0]  in_ch3_in_q,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [15:0]       out_ch0_out_i,
  output logic signed [15:0]       out_ch0_out_q,
  output logic signed [15:0]       out_ch1_out_i,
  output logic signed [15:0]       out_ch1_out_q,
  output logic signed [15:0]       out_ch2_out_i,
  output logic signed [15:0]       out_ch2_out_q,
  output logic signed [15:0]       out_ch3_out_i,
  output logic signed [15:0]       out_ch3_out_q,
  output logic                     out_frame_last
);

  logic [MAX_CH-1:0][SAMPLE_W-1:0] smp_i;
  logic [MAX_CH-1:0][SAMPLE_W-1:0] smp_q;
  logic [MAX_CH-1:0][SAMPLE_W-1:0] res_i;
  logic [MAX_CH-1:0][SAMPLE_W-1:0] res_q;
  logic      push;
  logic      q_full;
  logic      q_valid;
  logic      pop;
  pfb_item_t front_item;
  pfb_item_t back_item;

  // pack sample ports, channel 0 in the low slot
  assign smp_i = {in_ch3_in_i, in_ch2_in_i, in_ch1_in_i, in_ch0_in_i};
  assign smp_q = {in_ch3_in_q, in_ch2_in_q, in_ch1_in_q, in_ch0_in_q};

  // front: accepts items, tracks frame position, bank and filled-frame count
  pfb_front #(.FRAME_LEN(FRAME_LEN), .TAP_COUNT(TAP_COUNT)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_coeff_index (in_coeff_index),
    .in_coeff_value (in_coeff_value),
    .in_smp_i       (smp_i),
    .in_smp_q       (smp_q),
    .q_full         (q_full),
    .push           (push),
    .item           (front_item)
  );

  // short queue decoupling front from back
  pfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_item  (back_item)
  );

  // back: ram access, multiply, accumulate, output register
  pfb_back #(
    .FRAME_LEN       (FRAME_LEN),
    .TAP_COUNT       (TAP_COUNT),
    .CHANNEL_COUNT   (CHANNEL_COUNT),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (back_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_i     (res_i),
    .out_q     (res_q),
    .out_last  (out_frame_last)
  );

  assign out_ch0_out_i = res_i[0];
  assign out_ch0_out_q = res_q[0];
  assign out_ch1_out_i = res_i[1];
  assign out_ch1_out_q = res_q[1];
  assign out_ch2_out_i = res_i[2];
  assign out_ch2_out_q = res_q[2];
  assign out_ch3_out_i = res_i[3];
  assign out_ch3_out_q = res_q[3];

endmodule
`default_nettype wire
